// ----- rtl/tntc_pkg.sv -----
// types and constants for the texture name token classifier
package tntc_pkg;

    localparam int unsigned NUM_PREFIX = 5;
    localparam int unsigned POS_W      = 9;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // ten character carpet prefix, written as character codes
    localparam logic [79:0] CARPET_TEXT = 80'h73686f705f6a7574616e;

    // prefixes left-justified in ten character slots
    localparam logic [79:0] PFX_TEXT [NUM_PREFIX] = '{
        {"water", 40'h0},
        {"hikari", 32'h0},
        {"kabe_", 40'h0},
        {"yuka_", 40'h0},
        CARPET_TEXT
    };
    localparam logic [3:0] PFX_LEN [NUM_PREFIX] = '{4'd5, 4'd6, 4'd5, 4'd5, 4'd10};

    localparam logic [7:0]  CH_N       = "n";
    localparam logic [7:0]  CH_W       = "w";
    localparam logic [7:0]  CH_U       = "u";
    localparam logic [7:0]  CH_V       = "v";
    localparam logic [7:0]  CH_UNDER   = "_";
    localparam logic [7:0]  CH_ZERO    = "0";
    localparam logic [7:0]  CH_THREE   = "3";
    localparam logic [31:0] TGA_TEXT   = ".tga";

    typedef struct packed {
        logic       water_prefix;
        logic       light_prefix;
        logic       wall_prefix;
        logic       floor_prefix;
        logic       carpet_prefix;
        logic       n_marker;
        logic       w_marker;
        logic [1:0] u_select;
        logic [1:0] v_select;
        logic       tga_extension;
    } flags_t;

    // character j (below 10) of prefix k
    function automatic logic [7:0] prefix_char(input int unsigned k, input logic [3:0] j);
        logic [3:0] slot;
        slot = 4'd9 - j;
        return PFX_TEXT[k][{slot, 3'b000} +: 8];
    endfunction

endpackage

// ----- rtl/tntc_if.sv -----
// stream interfaces for the character input and the flag word output
interface tntc_name_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_name;

    modport source (output valid, output char_code, output end_of_name, input ready);
    modport sink   (input valid, input char_code, input end_of_name, output ready);
endinterface

interface tntc_flags_if;
    logic       valid;
    logic       ready;
    logic       water_prefix;
    logic       light_prefix;
    logic       wall_prefix;
    logic       floor_prefix;
    logic       carpet_prefix;
    logic       n_marker;
    logic       w_marker;
    logic [1:0] u_select;
    logic [1:0] v_select;
    logic       tga_extension;

    modport source (output valid, output water_prefix, output light_prefix,
                    output wall_prefix, output floor_prefix, output carpet_prefix,
                    output n_marker, output w_marker, output u_select,
                    output v_select, output tga_extension, input ready);
    modport sink   (input valid, input water_prefix, input light_prefix,
                    input wall_prefix, input floor_prefix, input carpet_prefix,
                    input n_marker, input w_marker, input u_select,
                    input v_select, input tga_extension, output ready);
endinterface

// ----- rtl/texture_name_token_classifier.sv -----
// an end-of-name transfer gives its flag word through the input register, then the result
// register; throughput: one character per cycle, back to back, except while input is stalled
// the scan state is updated by one pass of logic per character behind the input register;
// only the result register can stall input, and only while an end-of-name item waits
// reset: asynchronous, active low; clears valids and returns the scan state to its
// start values (history and flags zero, all prefixes still possible)
module texture_name_token_classifier #(
    parameter int unsigned SCAN_LIMIT = 256
) (
    input  logic   clk,
    input  logic   rst_n,
    tntc_name_if.sink    name_chars,
    tntc_flags_if.source flag_words
);
    import tntc_pkg::*;

    localparam logic [10:0] LIMIT_2 = 11'(SCAN_LIMIT + 2);
    localparam logic [10:0] LIMIT_3 = 11'(SCAN_LIMIT + 3);
    localparam logic [10:0] LIMIT_4 = 11'(SCAN_LIMIT + 4);

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_char_reg;
    logic       s1_last_reg;

    // scan state
    logic [23:0]           recent_reg, recent_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [NUM_PREFIX-1:0] alive_reg, alive_next;
    logic                  found_n_reg, found_n_next;
    logic                  found_w_reg, found_w_next;
    logic                  found_tga_reg, found_tga_next;
    logic [1:0]            u_choice_reg, u_choice_next;
    logic [1:0]            v_choice_reg, v_choice_next;
    logic                  stopped_reg, stopped_next;

    // result register
    logic   out_valid_reg;
    flags_t out_data_reg;
    flags_t result;

    logic out_free;
    logic s1_advance;

    assign out_free   = !out_valid_reg || flag_words.ready;
    assign s1_advance = s1_valid_reg && (!s1_last_reg || out_free);
    assign name_chars.ready = !s1_valid_reg || s1_advance;

    always_comb
    begin
        logic [31:0]           win;
        logic [10:0]           pos_inc;
        logic                  room;
        logic                  rng2, rng3, rng4;
        logic [23:0]           recent_upd;
        logic [POS_W-1:0]      pos_upd;
        logic [NUM_PREFIX-1:0] alive_upd;
        logic                  fn_upd, fw_upd, ftga_upd;
        logic [1:0]            u_upd, v_upd;
        logic                  stop_upd;

        win     = {recent_reg, s1_char_reg};
        pos_inc = {2'b00, pos_reg} + 11'd1;
        room    = (pos_reg != POS_MAX);
        rng2    = room && (pos_inc < LIMIT_2);
        rng3    = room && (pos_inc < LIMIT_3);
        rng4    = room && (pos_inc < LIMIT_4);

        recent_upd = recent_reg;
        pos_upd    = pos_reg;
        alive_upd  = alive_reg;
        fn_upd     = found_n_reg;
        fw_upd     = found_w_reg;
        ftga_upd   = found_tga_reg;
        u_upd      = u_choice_reg;
        v_upd      = v_choice_reg;
        stop_upd   = stopped_reg;

        if (!stopped_reg)
        begin
            if (s1_char_reg == 8'd0)
            begin
                stop_upd = 1'b1;
            end
            else
            begin
                for (int unsigned k = 0; k < NUM_PREFIX; k++)
                begin
                    if ((pos_reg < POS_W'(PFX_LEN[k]))
                        && (prefix_char(k, pos_reg[3:0]) != s1_char_reg))
                    begin
                        alive_upd[k] = 1'b0;
                    end
                end
                if (rng2 && win[15:0] == {CH_N, CH_UNDER})
                    fn_upd = 1'b1;
                if (rng2 && win[15:0] == {CH_W, CH_UNDER})
                    fw_upd = 1'b1;
                if (rng3 && win[7:0] == CH_UNDER && win[15:8] >= CH_ZERO
                    && win[15:8] <= CH_THREE)
                begin
                    if (win[23:16] == CH_U)
                        u_upd = win[9:8];
                    if (win[23:16] == CH_V)
                        v_upd = win[9:8];
                end
                if (rng4 && win == TGA_TEXT)
                    ftga_upd = 1'b1;
                recent_upd = win[23:0];
                if (room)
                    pos_upd = pos_reg + POS_W'(1);
            end
        end

        result.water_prefix  = alive_upd[0] && (pos_upd >= POS_W'(PFX_LEN[0]));
        result.light_prefix  = alive_upd[1] && (pos_upd >= POS_W'(PFX_LEN[1]));
        result.wall_prefix   = alive_upd[2] && (pos_upd >= POS_W'(PFX_LEN[2]));
        result.floor_prefix  = alive_upd[3] && (pos_upd >= POS_W'(PFX_LEN[3]));
        result.carpet_prefix = alive_upd[4] && (pos_upd >= POS_W'(PFX_LEN[4]));
        result.n_marker      = fn_upd;
        result.w_marker      = fw_upd;
        result.u_select      = u_upd;
        result.v_select      = v_upd;
        result.tga_extension = ftga_upd;

        recent_next    = recent_reg;
        pos_next       = pos_reg;
        alive_next     = alive_reg;
        found_n_next   = found_n_reg;
        found_w_next   = found_w_reg;
        found_tga_next = found_tga_reg;
        u_choice_next  = u_choice_reg;
        v_choice_next  = v_choice_reg;
        stopped_next   = stopped_reg;

        if (s1_advance)
        begin
            if (s1_last_reg)
            begin
                // name finished: back to start values
                recent_next    = '0;
                pos_next       = '0;
                alive_next     = '1;
                found_n_next   = 1'b0;
                found_w_next   = 1'b0;
                found_tga_next = 1'b0;
                u_choice_next  = '0;
                v_choice_next  = '0;
                stopped_next   = 1'b0;
            end
            else
            begin
                recent_next    = recent_upd;
                pos_next       = pos_upd;
                alive_next     = alive_upd;
                found_n_next   = fn_upd;
                found_w_next   = fw_upd;
                found_tga_next = ftga_upd;
                u_choice_next  = u_upd;
                v_choice_next  = v_upd;
                stopped_next   = stop_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            recent_reg    <= '0;
            pos_reg       <= '0;
            alive_reg     <= '1;
            found_n_reg   <= 1'b0;
            found_w_reg   <= 1'b0;
            found_tga_reg <= 1'b0;
            u_choice_reg  <= '0;
            v_choice_reg  <= '0;
            stopped_reg   <= 1'b0;
        end
        else
        begin
            if (name_chars.ready)
                s1_valid_reg <= name_chars.valid;
            if (s1_advance && s1_last_reg)
                out_valid_reg <= 1'b1;
            else if (flag_words.ready)
                out_valid_reg <= 1'b0;
            recent_reg    <= recent_next;
            pos_reg       <= pos_next;
            alive_reg     <= alive_next;
            found_n_reg   <= found_n_next;
            found_w_reg   <= found_w_next;
            found_tga_reg <= found_tga_next;
            u_choice_reg  <= u_choice_next;
            v_choice_reg  <= v_choice_next;
            stopped_reg   <= stopped_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (name_chars.valid && name_chars.ready)
        begin
            s1_char_reg <= name_chars.char_code;
            s1_last_reg <= name_chars.end_of_name;
        end
        if (s1_advance && s1_last_reg)
            out_data_reg <= result;
    end

    assign flag_words.valid         = out_valid_reg;
    assign flag_words.water_prefix  = out_data_reg.water_prefix;
    assign flag_words.light_prefix  = out_data_reg.light_prefix;
    assign flag_words.wall_prefix   = out_data_reg.wall_prefix;
    assign flag_words.floor_prefix  = out_data_reg.floor_prefix;
    assign flag_words.carpet_prefix = out_data_reg.carpet_prefix;
    assign flag_words.n_marker      = out_data_reg.n_marker;
    assign flag_words.w_marker      = out_data_reg.w_marker;
    assign flag_words.u_select      = out_data_reg.u_select;
    assign flag_words.v_select      = out_data_reg.v_select;
    assign flag_words.tga_extension = out_data_reg.tga_extension;

    // input stalls only behind a finished name waiting on a full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !name_chars.ready |-> (s1_valid_reg && s1_last_reg && out_valid_reg && !flag_words.ready))
        else $error("input stalled without a waiting result");

    // state is back at its start values after a name completes
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_last_reg) |=> (pos_reg == '0 && alive_reg == '1 && !stopped_reg))
        else $error("scan state not cleared after end of name");

    // a digit select needs at least three characters of history
    a_select_history: assert property (@(posedge clk) disable iff (!rst_n)
        (u_choice_reg != '0 || v_choice_reg != '0) |-> (pos_reg >= POS_W'(3)))
        else $error("digit select set with too short a history");

    // a result is loaded only from a consumed end-of-name item
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_last_reg))
        else $error("result produced without an end-of-name item");

endmodule
